// ===== src/sqlt_pkg.sv =====
`timescale 1ns / 1ps

package sqlt_pkg;

  localparam int KEYWORD_MAX_LEN = 7;
  localparam int KW_NUM = 8;
  localparam int KW_CHARS = 7;

  localparam logic [7:0] KW_TEXT [0:KW_NUM-1][0:KW_CHARS-1] = '{
    '{"s", "e", "l", "e", "c", "t", 8'h00},
    '{"f", "r", "o", "m", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "e", "r", "e", 8'h00, 8'h00},
    '{"c", "o", "u", "n", "t", 8'h00, 8'h00},
    '{"c", "r", "e", "a", "t", "e", 8'h00},
    '{"t", "a", "b", "l", "e", 8'h00, 8'h00},
    '{"p", "r", "i", "m", "a", "r", "y"},
    '{"k", "e", "y", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [0:KW_NUM-1] = '{
    3'd6, 3'd4, 3'd5, 3'd5, 3'd6, 3'd5, 3'd7, 3'd3
  };

  localparam logic [3:0] KIND_IDENT    = 4'd0;
  localparam logic [3:0] KIND_STRING   = 4'd1;
  localparam logic [3:0] KIND_OPER     = 4'd2;
  localparam logic [3:0] KIND_LPAREN   = 4'd3;
  localparam logic [3:0] KIND_RPAREN   = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_FIRST_KW = 4'd6;
  localparam logic [3:0] KIND_EOF      = 4'd14;
  localparam logic [3:0] KIND_UNKNOWN  = 4'd15;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_IDENT  = 2'd2,
    MODE_STRING = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    CL_SPACE  = 4'd0,
    CL_LPAREN = 4'd1,
    CL_RPAREN = 4'd2,
    CL_COMMA  = 4'd3,
    CL_QUOTE  = 4'd4,
    CL_OPER   = 4'd5,
    CL_ALNUM  = 4'd6,
    CL_USTAR  = 4'd7,
    CL_OTHER  = 4'd8
  } class_t;

  typedef enum logic [3:0] {
    IT_KW        = 4'd0,
    IT_BUF       = 4'd1,
    IT_IDENT_C   = 4'd2,
    IT_IDENT_END = 4'd3,
    IT_STR_C     = 4'd4,
    IT_STR_END   = 4'd5,
    IT_OPER      = 4'd6,
    IT_LPAREN    = 4'd7,
    IT_RPAREN    = 4'd8,
    IT_COMMA     = 4'd9,
    IT_UNKNOWN   = 4'd10,
    IT_EOF       = 4'd11
  } sel_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic       bvalid;
    logic       tend;
  } item_t;

  typedef struct packed {
    logic  load;
    logic  emit;
    sel_t  sel;
    logic  store;
    logic  first;
    logic  clr_len;
    logic  flush;
    logic  release_hold;
    logic  mode_wr;
    mode_t mode;
  } cmd_t;

  typedef struct packed {
    mode_t  mode;
    class_t cls;
    logic   w_full;
    logic   match;
    logic   fl_last;
    logic   eoi;
    logic   push_ok;
    logic   out_free;
    logic   hold_v;
  } sts_t;

endpackage

// ===== src/sqlt_ctrl.sv =====
`timescale 1ns / 1ps

module sqlt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  sqlt_pkg::sts_t  sts,
  output sqlt_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IN    = 7'b0000001,
    S_MAIN  = 7'b0000010,
    S_START = 7'b0000100,
    S_TAIL  = 7'b0001000,
    S_FLUSH = 7'b0010000,
    S_EOF   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ret_tail_r, ret_tail_nxt;

  assign in_tready = (state_r == S_IN);

  always_comb begin
    state_nxt        = state_r;
    ret_tail_nxt     = ret_tail_r;
    cmd.load         = 1'b0;
    cmd.emit         = 1'b0;
    cmd.sel          = sqlt_pkg::IT_EOF;
    cmd.store        = 1'b0;
    cmd.first        = 1'b0;
    cmd.clr_len      = 1'b0;
    cmd.flush        = 1'b0;
    cmd.release_hold = 1'b0;
    cmd.mode_wr      = 1'b0;
    cmd.mode         = sqlt_pkg::MODE_IDLE;
    unique case (state_r)
      S_IN: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MAIN;
        end
      end
      S_MAIN: begin
        unique case (sts.mode)
          sqlt_pkg::MODE_WORD: begin
            if (sts.cls == sqlt_pkg::CL_ALNUM && !sts.w_full) begin
              cmd.store = 1'b1;
              state_nxt = S_TAIL;
            end else if (sts.cls != sqlt_pkg::CL_ALNUM && sts.match) begin
              if (sts.push_ok) begin
                cmd.emit    = 1'b1;
                cmd.sel     = sqlt_pkg::IT_KW;
                cmd.clr_len = 1'b1;
                cmd.mode_wr = 1'b1;
                state_nxt   = S_START;
              end
            end else begin
              ret_tail_nxt = 1'b0;
              state_nxt    = S_FLUSH;
            end
          end
          sqlt_pkg::MODE_IDENT: begin
            if (sts.push_ok) begin
              cmd.emit = 1'b1;
              if (sts.cls == sqlt_pkg::CL_ALNUM || sts.cls == sqlt_pkg::CL_USTAR) begin
                cmd.sel   = sqlt_pkg::IT_IDENT_C;
                state_nxt = S_TAIL;
              end else begin
                cmd.sel   = sqlt_pkg::IT_IDENT_END;
                state_nxt = S_START;
              end
            end
          end
          sqlt_pkg::MODE_STRING: begin
            if (sts.push_ok) begin
              cmd.emit  = 1'b1;
              state_nxt = S_TAIL;
              if (sts.cls == sqlt_pkg::CL_QUOTE) begin
                cmd.sel     = sqlt_pkg::IT_STR_END;
                cmd.mode_wr = 1'b1;
                cmd.mode    = sqlt_pkg::MODE_IDLE;
              end else begin
                cmd.sel = sqlt_pkg::IT_STR_C;
              end
            end
          end
          default: begin
            state_nxt = S_START;
          end
        endcase
      end
      S_START: begin
        unique case (sts.cls)
          sqlt_pkg::CL_SPACE: begin
            cmd.mode_wr = 1'b1;
            state_nxt   = S_TAIL;
          end
          sqlt_pkg::CL_QUOTE: begin
            cmd.mode_wr = 1'b1;
            cmd.mode    = sqlt_pkg::MODE_STRING;
            state_nxt   = S_TAIL;
          end
          sqlt_pkg::CL_ALNUM: begin
            cmd.first   = 1'b1;
            cmd.mode_wr = 1'b1;
            cmd.mode    = sqlt_pkg::MODE_WORD;
            state_nxt   = S_TAIL;
          end
          sqlt_pkg::CL_USTAR: begin
            if (sts.push_ok) begin
              cmd.emit    = 1'b1;
              cmd.sel     = sqlt_pkg::IT_IDENT_C;
              cmd.mode_wr = 1'b1;
              cmd.mode    = sqlt_pkg::MODE_IDENT;
              state_nxt   = S_TAIL;
            end
          end
          default: begin
            if (sts.push_ok) begin
              cmd.emit    = 1'b1;
              cmd.mode_wr = 1'b1;
              state_nxt   = S_TAIL;
              unique case (sts.cls)
                sqlt_pkg::CL_LPAREN: cmd.sel = sqlt_pkg::IT_LPAREN;
                sqlt_pkg::CL_RPAREN: cmd.sel = sqlt_pkg::IT_RPAREN;
                sqlt_pkg::CL_COMMA:  cmd.sel = sqlt_pkg::IT_COMMA;
                sqlt_pkg::CL_OPER:   cmd.sel = sqlt_pkg::IT_OPER;
                default:             cmd.sel = sqlt_pkg::IT_UNKNOWN;
              endcase
            end
          end
        endcase
      end
      S_TAIL: begin
        if (!sts.eoi) begin
          state_nxt = S_DONE;
        end else begin
          unique case (sts.mode)
            sqlt_pkg::MODE_WORD: begin
              if (!sts.match) begin
                ret_tail_nxt = 1'b1;
                state_nxt    = S_FLUSH;
              end else if (sts.push_ok) begin
                cmd.emit    = 1'b1;
                cmd.sel     = sqlt_pkg::IT_KW;
                cmd.clr_len = 1'b1;
                cmd.mode_wr = 1'b1;
                state_nxt   = S_EOF;
              end
            end
            sqlt_pkg::MODE_IDENT: begin
              if (sts.push_ok) begin
                cmd.emit  = 1'b1;
                cmd.sel   = sqlt_pkg::IT_IDENT_END;
                state_nxt = S_EOF;
              end
            end
            sqlt_pkg::MODE_STRING: begin
              if (sts.push_ok) begin
                cmd.emit  = 1'b1;
                cmd.sel   = sqlt_pkg::IT_STR_END;
                state_nxt = S_EOF;
              end
            end
            default: begin
              state_nxt = S_EOF;
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (sts.push_ok) begin
          cmd.emit  = 1'b1;
          cmd.sel   = sqlt_pkg::IT_BUF;
          cmd.flush = 1'b1;
          if (sts.fl_last) begin
            cmd.mode_wr = 1'b1;
            cmd.mode    = sqlt_pkg::MODE_IDENT;
            state_nxt   = ret_tail_r ? S_TAIL : S_MAIN;
          end
        end
      end
      S_EOF: begin
        if (sts.push_ok) begin
          cmd.emit    = 1'b1;
          cmd.sel     = sqlt_pkg::IT_EOF;
          cmd.clr_len = 1'b1;
          cmd.mode_wr = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.hold_v) begin
          state_nxt = S_IN;
        end else if (sts.out_free) begin
          cmd.release_hold = 1'b1;
          state_nxt        = S_IN;
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IN;
      ret_tail_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_tail_r <= ret_tail_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.push_ok)
    else $error("item pushed while hold and output are both full");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.release_hold |-> (sts.hold_v && sts.out_free))
    else $error("hold released without a pending item or free output");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IN) |-> !sts.hold_v)
    else $error("new byte taken with an undelivered result in hold");

endmodule

// ===== src/sqlt_dp.sv =====
`timescale 1ns / 1ps

module sqlt_dp #(
  parameter int KEYWORD_MAX_LEN = sqlt_pkg::KEYWORD_MAX_LEN
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_byte,
  input  logic            in_eoi,
  input  sqlt_pkg::cmd_t  cmd,
  output sqlt_pkg::sts_t  sts,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output logic [5:0]      out_tuser
);

  localparam int LW = $clog2(KEYWORD_MAX_LEN + 1);
  localparam int IW = $clog2(KEYWORD_MAX_LEN);

  logic [7:0]           c_r;
  logic                 eoi_r;
  logic [7:0]           buf_r [KEYWORD_MAX_LEN];
  logic [LW-1:0]        w_r, w_nxt;
  logic [IW-1:0]        fl_r, fl_nxt;
  sqlt_pkg::mode_t      mode_r, mode_nxt;
  sqlt_pkg::class_t     cls;
  logic [sqlt_pkg::KW_NUM-1:0] hit;
  logic [2:0]           kw_idx;
  logic                 fl_last;
  sqlt_pkg::item_t      new_item;
  sqlt_pkg::item_t      hold_r, hold_nxt;
  logic                 hold_v_r, hold_v_nxt;
  sqlt_pkg::item_t      out_r, out_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 out_free;

  function automatic logic [7:0] lower(input logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
  endfunction

  always_comb begin
    priority if (c_r == " " || (c_r >= 8'd9 && c_r <= 8'd13)) cls = sqlt_pkg::CL_SPACE;
    else if (c_r == "(")                                       cls = sqlt_pkg::CL_LPAREN;
    else if (c_r == ")")                                       cls = sqlt_pkg::CL_RPAREN;
    else if (c_r == ",")                                       cls = sqlt_pkg::CL_COMMA;
    else if (c_r == 8'h27)                                     cls = sqlt_pkg::CL_QUOTE;
    else if (c_r == "=" || c_r == "<" || c_r == ">")           cls = sqlt_pkg::CL_OPER;
    else if ((c_r >= "0" && c_r <= "9") || (c_r >= "A" && c_r <= "Z")
             || (c_r >= "a" && c_r <= "z"))                    cls = sqlt_pkg::CL_ALNUM;
    else if (c_r == "_" || c_r == "*")                         cls = sqlt_pkg::CL_USTAR;
    else                                                       cls = sqlt_pkg::CL_OTHER;
  end

  always_comb begin
    logic eq;
    for (int k = 0; k < sqlt_pkg::KW_NUM; k++) begin
      eq = (w_r == LW'(sqlt_pkg::KW_LEN[k]));
      for (int j = 0; j < sqlt_pkg::KW_CHARS; j++) begin
        if (j < int'(sqlt_pkg::KW_LEN[k])) begin
          eq = eq && (lower(buf_r[j]) == sqlt_pkg::KW_TEXT[k][j]);
        end
      end
      hit[k] = eq;
    end
  end

  always_comb begin
    kw_idx = 3'd0;
    for (int k = sqlt_pkg::KW_NUM - 1; k >= 0; k--) begin
      if (hit[k]) begin
        kw_idx = 3'(k);
      end
    end
  end

  assign fl_last  = ((LW'(fl_r) + LW'(1)) == w_r);
  assign out_free = !out_v_r || out_tready;

  always_comb begin
    new_item = '{kind: sqlt_pkg::KIND_EOF, data: 8'd0, bvalid: 1'b0, tend: 1'b1};
    unique case (cmd.sel)
      sqlt_pkg::IT_KW:        new_item.kind = sqlt_pkg::KIND_FIRST_KW + 4'(kw_idx);
      sqlt_pkg::IT_BUF:       new_item = '{sqlt_pkg::KIND_IDENT, buf_r[fl_r], 1'b1, 1'b0};
      sqlt_pkg::IT_IDENT_C:   new_item = '{sqlt_pkg::KIND_IDENT, c_r, 1'b1, 1'b0};
      sqlt_pkg::IT_IDENT_END: new_item.kind = sqlt_pkg::KIND_IDENT;
      sqlt_pkg::IT_STR_C:     new_item = '{sqlt_pkg::KIND_STRING, c_r, 1'b1, 1'b0};
      sqlt_pkg::IT_STR_END:   new_item.kind = sqlt_pkg::KIND_STRING;
      sqlt_pkg::IT_OPER:      new_item = '{sqlt_pkg::KIND_OPER, c_r, 1'b1, 1'b1};
      sqlt_pkg::IT_LPAREN:    new_item.kind = sqlt_pkg::KIND_LPAREN;
      sqlt_pkg::IT_RPAREN:    new_item.kind = sqlt_pkg::KIND_RPAREN;
      sqlt_pkg::IT_COMMA:     new_item.kind = sqlt_pkg::KIND_COMMA;
      sqlt_pkg::IT_UNKNOWN:   new_item.kind = sqlt_pkg::KIND_UNKNOWN;
      default:                new_item.kind = sqlt_pkg::KIND_EOF;
    endcase
  end

  always_comb begin
    w_nxt    = w_r;
    fl_nxt   = fl_r;
    mode_nxt = mode_r;
    if (cmd.store) begin
      w_nxt = w_r + LW'(1);
    end
    if (cmd.first) begin
      w_nxt = LW'(1);
    end
    if (cmd.clr_len) begin
      w_nxt = '0;
    end
    if (cmd.flush) begin
      if (fl_last) begin
        fl_nxt = '0;
        w_nxt  = '0;
      end else begin
        fl_nxt = fl_r + IW'(1);
      end
    end
    if (cmd.mode_wr) begin
      mode_nxt = cmd.mode;
    end
  end

  // hold keeps one result back so the last one of a byte can be flagged
  always_comb begin
    hold_nxt     = hold_r;
    hold_v_nxt   = hold_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_v_nxt    = out_v_r && !out_tready;
    if (cmd.emit) begin
      if (hold_v_r) begin
        out_nxt      = hold_r;
        out_last_nxt = 1'b0;
        out_v_nxt    = 1'b1;
      end
      hold_nxt   = new_item;
      hold_v_nxt = 1'b1;
    end
    if (cmd.release_hold) begin
      out_nxt      = hold_r;
      out_last_nxt = 1'b1;
      out_v_nxt    = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= '0;
      fl_r     <= '0;
      mode_r   <= sqlt_pkg::MODE_IDLE;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      w_r      <= w_nxt;
      fl_r     <= fl_nxt;
      mode_r   <= mode_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r   <= in_byte;
      eoi_r <= in_eoi;
    end
    if (cmd.store) begin
      buf_r[w_r[IW-1:0]] <= c_r;
    end
    if (cmd.first) begin
      buf_r[0] <= c_r;
    end
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.mode     = mode_r;
  assign sts.cls      = cls;
  assign sts.w_full   = (w_r == LW'(KEYWORD_MAX_LEN));
  assign sts.match    = |hit;
  assign sts.fl_last  = fl_last;
  assign sts.eoi      = eoi_r;
  assign sts.push_ok  = !hold_v_r || out_free;
  assign sts.out_free = out_free;
  assign sts.hold_v   = hold_v_r;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.data;
  assign out_tlast  = out_r.tend;
  assign out_tuser  = {out_last_r, out_r.bvalid, out_r.kind};

  assert property (@(posedge clk) disable iff (!rst_n)
    w_r <= LW'(KEYWORD_MAX_LEN))
    else $error("word length beyond buffer depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == sqlt_pkg::MODE_WORD) |-> (w_r != '0))
    else $error("word mode with empty buffer");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> (mode_r == sqlt_pkg::MODE_WORD && LW'(fl_r) < w_r))
    else $error("flush index outside buffered word");

endmodule

// ===== src/sql_keyword_tokenizer.sv =====
`timescale 1ns / 1ps
// Each in beat is served in full by the sequencer before in_tready rises for the next byte;
// its results pass through the hold register and then the output register to out_tvalid.
// A buffered word flushed as identifier yields one result per character, end of input adds
// an EOF token, and out_tready backpressure stalls the sequencer.
// Reset: synchronous active-low rst_n clears the sequencer, scan mode, word length,
// flush index, hold valid and output valid; the word buffer is not cleared.

module sql_keyword_tokenizer #(
  parameter int KEYWORD_MAX_LEN = sqlt_pkg::KEYWORD_MAX_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_input
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] token_byte
  output logic       out_tlast,  // token_end
  output logic [5:0] out_tuser   // [3:0] token_kind, [4] byte_valid, [5] last_result
);

  sqlt_pkg::cmd_t cmd;
  sqlt_pkg::sts_t sts;

  sqlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sqlt_dp #(
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_eoi     (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef logic [7:0] text_q_t[$];

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] chr;
    logic       bvalid;
    logic       tend;
    logic       lastr;
  } token_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [5:0] out_tuser;

  sql_keyword_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string  kw_list [8] = '{"select", "from", "where", "count",
                          "create", "table", "primary", "key"};

  sqlt_pkg::mode_t lex_mode = sqlt_pkg::MODE_IDLE;
  logic [7:0] word_buf [sqlt_pkg::KEYWORD_MAX_LEN];
  int         word_len = 0;
  token_t     burst[$];
  token_t     due_tokens[$];
  int         errors = 0;
  bit         tx_idle = 1'b1;
  bit         rx_idle = 1'b1;
  int         rx_hold = 0;

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void put(logic [3:0] kind, logic [7:0] chr, logic bv, logic te);
    token_t t;
    t.kind   = kind;
    t.chr    = chr;
    t.bvalid = bv;
    t.tend   = te;
    t.lastr  = 1'b0;
    burst.push_back(t);
  endfunction

  function automatic int keyword_index();
    bit same;
    for (int k = 0; k < 8; k++) begin
      if (kw_list[k].len() == word_len) begin
        same = 1'b1;
        for (int j = 0; j < word_len; j++)
          if (to_lower(word_buf[j]) != kw_list[k][j]) same = 1'b0;
        if (same) return k;
      end
    end
    return -1;
  endfunction

  function automatic void flush_word();
    for (int j = 0; j < word_len; j++) put(sqlt_pkg::KIND_IDENT, word_buf[j], 1'b1, 1'b0);
    word_len = 0;
  endfunction

  function automatic bit close_word();
    int k;
    k = keyword_index();
    if (k >= 0) begin
      put(sqlt_pkg::KIND_FIRST_KW + 4'(k), 8'h00, 1'b0, 1'b1);
      word_len = 0;
      return 1'b1;
    end
    flush_word();
    return 1'b0;
  endfunction

  function automatic void start_token(logic [7:0] c);
    lex_mode = sqlt_pkg::MODE_IDLE;
    if (is_space(c)) return;
    if (c == "(") put(sqlt_pkg::KIND_LPAREN, 8'h00, 1'b0, 1'b1);
    else if (c == ")") put(sqlt_pkg::KIND_RPAREN, 8'h00, 1'b0, 1'b1);
    else if (c == ",") put(sqlt_pkg::KIND_COMMA, 8'h00, 1'b0, 1'b1);
    else if (c == "'") lex_mode = sqlt_pkg::MODE_STRING;
    else if (c == "=" || c == "<" || c == ">") put(sqlt_pkg::KIND_OPER, c, 1'b1, 1'b1);
    else if (is_alnum(c)) begin
      word_buf[0] = c;
      word_len = 1;
      lex_mode = sqlt_pkg::MODE_WORD;
    end else if (c == "_" || c == "*") begin
      put(sqlt_pkg::KIND_IDENT, c, 1'b1, 1'b0);
      lex_mode = sqlt_pkg::MODE_IDENT;
    end else put(sqlt_pkg::KIND_UNKNOWN, 8'h00, 1'b0, 1'b1);
  endfunction

  function automatic void lex_step(logic [7:0] c, logic eoi);
    burst.delete();
    case (lex_mode)
      sqlt_pkg::MODE_WORD: begin
        if (is_alnum(c)) begin
          if (word_len < sqlt_pkg::KEYWORD_MAX_LEN) begin
            word_buf[word_len] = c;
            word_len++;
          end else begin
            flush_word();
            put(sqlt_pkg::KIND_IDENT, c, 1'b1, 1'b0);
            lex_mode = sqlt_pkg::MODE_IDENT;
          end
        end else if (close_word()) begin
          start_token(c);
        end else if (c == "_" || c == "*") begin
          put(sqlt_pkg::KIND_IDENT, c, 1'b1, 1'b0);
          lex_mode = sqlt_pkg::MODE_IDENT;
        end else begin
          put(sqlt_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1);
          start_token(c);
        end
      end
      sqlt_pkg::MODE_IDENT: begin
        if (is_alnum(c) || c == "_" || c == "*") begin
          put(sqlt_pkg::KIND_IDENT, c, 1'b1, 1'b0);
        end else begin
          put(sqlt_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1);
          start_token(c);
        end
      end
      sqlt_pkg::MODE_STRING: begin
        if (c == "'") begin
          put(sqlt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1);
          lex_mode = sqlt_pkg::MODE_IDLE;
        end else begin
          put(sqlt_pkg::KIND_STRING, c, 1'b1, 1'b0);
        end
      end
      default: start_token(c);
    endcase
    if (eoi) begin
      if (lex_mode == sqlt_pkg::MODE_WORD) begin
        if (!close_word()) put(sqlt_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1);
      end else if (lex_mode == sqlt_pkg::MODE_IDENT) begin
        put(sqlt_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1);
      end else if (lex_mode == sqlt_pkg::MODE_STRING) begin
        put(sqlt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1);
      end
      put(sqlt_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1);
      lex_mode = sqlt_pkg::MODE_IDLE;
      word_len = 0;
    end
    if (burst.size() > 0) burst[burst.size()-1].lastr = 1'b1;
    foreach (burst[i]) due_tokens.push_back(burst[i]);
  endfunction

  function automatic void check_field(string what, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    token_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_tokens.size() == 0) begin
        $display("%0t: result expected none got kind %0h byte %0h",
                 $time, out_tuser[3:0], out_tdata);
        errors++;
      end else begin
        e = due_tokens.pop_front();
        check_field("token_kind", e.kind, out_tuser[3:0]);
        check_field("token_byte", e.chr, out_tdata);
        check_field("byte_valid", e.bvalid, out_tuser[4]);
        check_field("token_end", e.tend, out_tlast);
        check_field("last_result", e.lastr, out_tuser[5]);
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = rx_hold + (rx_idle ? $urandom_range(0, 17) : 0);
      rx_hold = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  task automatic feed_char(input logic [7:0] c, input logic eoi);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= c;
    in_tlast  <= eoi;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    lex_step(c, eoi);
    @(negedge clk);
  endtask

  task automatic feed_text(input text_q_t txt);
    foreach (txt[i]) feed_char(txt[i], i == txt.size() - 1);
  endtask

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? 8'h20 : 8'(r + 8);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 10) return 8'(48 + r);
    if (r < 36) return 8'(65 + r - 10);
    if (r < 62) return 8'(97 + r - 36);
    return (r == 62) ? "_" : "*";
  endfunction

  task automatic make_text(output text_q_t txt, input int want);
    int         k;
    int         n;
    logic [7:0] c;
    string      punct;
    punct = "(),=<>";
    txt.delete();
    while (txt.size() < want) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          k = $urandom_range(0, 7);
          for (int j = 0; j < kw_list[k].len(); j++) begin
            c = kw_list[k][j];
            if ($urandom_range(0, 1)) c = c - 8'd32;
            txt.push_back(c);
          end
        end
        3, 4: begin
          n = $urandom_range(1, 10);
          repeat (n) txt.push_back(rand_word_char());
        end
        5: begin
          txt.push_back("'");
          n = $urandom_range(0, 6);
          repeat (n) begin
            do c = 8'($urandom_range(0, 255)); while (c == "'");
            txt.push_back(c);
          end
          if ($urandom_range(0, 4) != 0) txt.push_back("'");
        end
        6: txt.push_back(punct[$urandom_range(0, 5)]);
        7: txt.push_back(8'($urandom_range(0, 255)));
        default: txt.push_back(rand_space());
      endcase
      case ($urandom_range(0, 3))
        0: ;
        1: txt.push_back(",");
        default: txt.push_back(rand_space());
      endcase
    end
  endtask

  task automatic test_punctuation();
    text_q_t txt;
    txt = '{"(", "=", "<", ">", ",", ")", 8'h00, 8'hff, "#", " "};
    feed_text(txt);
  endtask

  task automatic test_keyword_boundary();
    text_q_t txt;
    txt = '{"K", "E", "Y", "*"};
    feed_text(txt);
  endtask

  task automatic test_long_run();
    text_q_t txt;
    txt = '{"A", "b", "c", "d", "e", "f", "g", "9"};
    feed_text(txt);
  endtask

  task automatic test_open_string();
    text_q_t txt;
    txt = '{"'", 8'hff};
    feed_text(txt);
  endtask

  task automatic test_backpressure();
    text_q_t txt;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    make_text(txt, 30);
    rx_hold = 400;
    feed_text(txt);
  endtask

  task automatic test_random_text();
    text_q_t txt;
    int      sent;
    int      pick;
    sent = 0;
    while (sent < 90) begin
      pick = $urandom_range(0, 3);
      tx_idle = pick[0];
      rx_idle = pick[1];
      make_text(txt, $urandom_range(4, 24));
      feed_text(txt);
      sent += txt.size();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_punctuation();
    test_keyword_boundary();
    test_long_run();
    test_open_string();
    test_backpressure();
    test_random_text();
    in_tvalid <= 1'b0;
    while (due_tokens.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
